/* design/iss_pkg.sv */
package iss_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;

  typedef enum logic [2:0] {
    REQ_APPEND    = 3'd0,
    REQ_PREPEND   = 3'd1,
    REQ_INSERT    = 3'd2,
    REQ_POP_LAST  = 3'd3,
    REQ_POP_FIRST = 3'd4,
    REQ_REMOVE    = 3'd5,
    REQ_READ      = 3'd6,
    REQ_CLEAR     = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_INDEX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_DN_RD,
    S_DN_WR,
    S_DONE
  } state_t;

endpackage

/* design/iss_ram.sv */
module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/indexed_sequence_store_unit.sv */
// Ordered store of up to CAPACITY signed words held in a single-port-write,
// registered-read RAM.
// Input channel: a request word (in_req_type, in_position, in_data_in) is
// taken at a rising edge where start is high and busy is low.
// Result channel: exactly one result word per request, shown for one cycle
// with out_strobe high; the receiver cannot stall it.
// Sequencing: append, prepend or insert at the end, clear and every rejected
// request give their result in the cycle after acceptance. Reads and pops
// pass through S_RD_WAIT. An insert or prepend that moves entries loops
// S_SH_RD/S_SH_WR then S_INS_WR; remove and pop first loop S_DN_RD/S_DN_WR.
// Each moved entry costs one RAM read and one RAM write, which sets the rate.
// busy stays high from acceptance until the cycle with out_strobe.
// A new request can be taken from the cycle after the strobe, so requests
// never overlap.
// Reset clears the entry count; RAM contents are not cleared, since only
// entries below the count are ever read.
module indexed_sequence_store_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_req_type,
  input  logic [iss_pkg::CNT_W-1:0]   in_position,
  input  logic signed [31:0]          in_data_in,
  output logic                        out_strobe,
  output logic signed [31:0]          out_data_out,
  output logic [iss_pkg::CNT_W-1:0]   out_entry_count,
  output logic [1:0]                  out_status
);
  import iss_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  req_t                req_r, req_nxt;
  logic [DATA_W-1:0]   data_r, data_nxt;
  logic [DATA_W-1:0]   dout_r, dout_nxt;
  status_t             status_r, status_nxt;

  logic                mem_we;
  logic [CNT_W-1:0]    waddr;
  logic [DATA_W-1:0]   wdata;
  logic [CNT_W-1:0]    raddr;
  logic [DATA_W-1:0]   rdata;
  logic [CNT_W-1:0]    ins_at;
  req_t                in_req;

  iss_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr[ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (raddr[ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign in_req = req_t'(in_req_type);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
    end
    idx_r    <= idx_nxt;
    lo_r     <= lo_nxt;
    req_r    <= req_nxt;
    data_r   <= data_nxt;
    dout_r   <= dout_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    lo_nxt     = lo_r;
    req_nxt    = req_r;
    data_nxt   = data_r;
    dout_nxt   = dout_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    waddr      = idx_r;
    wdata      = rdata;
    raddr      = idx_r;
    ins_at     = count_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_req;
          data_nxt   = in_data_in;
          dout_nxt   = '0;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          case (in_req) inside
            REQ_APPEND, REQ_PREPEND, REQ_INSERT: begin
              if (in_req == REQ_PREPEND) begin
                ins_at = '0;
              end else if (in_req == REQ_INSERT) begin
                ins_at = in_position;
              end
              if (count_r >= CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else if (ins_at > count_r) begin
                status_nxt = ST_INDEX;
              end else if (ins_at == count_r) begin
                mem_we    = 1'b1;
                waddr     = count_r;
                wdata     = in_data_in;
                count_nxt = count_r + 1'b1;
              end else begin
                idx_nxt   = count_r;
                lo_nxt    = ins_at;
                state_nxt = S_SH_RD;
              end
            end
            REQ_POP_LAST, REQ_POP_FIRST: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                raddr     = (in_req == REQ_POP_LAST) ? count_r - 1'b1 : '0;
                idx_nxt   = '0;
                state_nxt = S_RD_WAIT;
              end
            end
            REQ_REMOVE, REQ_READ: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (in_position >= count_r) begin
                status_nxt = ST_INDEX;
              end else if (in_req == REQ_READ) begin
                raddr     = in_position;
                state_nxt = S_RD_WAIT;
              end else begin
                idx_nxt   = in_position;
                state_nxt = S_DN_RD;
              end
            end
            default: begin
              count_nxt = '0;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        dout_nxt = rdata;
        if (req_r == REQ_POP_LAST) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end else if (req_r == REQ_POP_FIRST) begin
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SH_RD: begin
        raddr     = idx_r - 1'b1;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        mem_we  = 1'b1;
        waddr   = idx_r;
        wdata   = rdata;
        idx_nxt = idx_r - 1'b1;
        state_nxt = (idx_r - 1'b1 == lo_r) ? S_INS_WR : S_SH_RD;
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        waddr     = lo_r;
        wdata     = data_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_DN_RD: begin
        if (idx_r + 1'b1 >= count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          raddr     = idx_r + 1'b1;
          state_nxt = S_DN_WR;
        end
      end
      S_DN_WR: begin
        mem_we    = 1'b1;
        waddr     = idx_r;
        wdata     = rdata;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_DN_RD;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = (state_r == S_DONE);
  assign out_data_out    = dout_r;
  assign out_entry_count = count_r;
  assign out_status      = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("Accepted request did not raise busy.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == ST_FULL |-> out_entry_count == CNT_W'(CAPACITY))
    else $error("Full status reported on a store that is not full.");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("Result strobe held for more than one cycle.");

endmodule
